// ===== rtl/dca_pkg.sv =====
// shared types and codes of the circular array deque
`default_nettype none

package dca_pkg;

    // field widths of the item and result
    localparam int IDX_W = 7;
    localparam int VAL_W = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_ADD = 2'd2,
        OP_REM = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_INS  = 2'd1,
        CMD_REM  = 2'd2,
        CMD_SET  = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        logic                    load_tap;
        t_cell_cmd               cmd;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

    // input item
    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_item;

    // result item
    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [IDX_W-1:0]        count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dca_cell.sv =====
// one cell of the deque chain: one element in logical order plus one read tap
`default_nettype none

module dca_cell #(
    parameter int POS = 0
) (
    input  wire                          i_clk,
    input  wire dca_pkg::t_cell_ctl      i_ctl,
    input  wire logic signed [31:0]      i_left_data,
    input  wire logic signed [31:0]      i_right_data,
    input  wire logic signed [31:0]      i_right_tap,
    output logic signed [31:0]           o_data,
    output logic signed [31:0]           o_tap
);
    import dca_pkg::*;

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] r_tap;
    logic signed [VAL_W-1:0] n_data;
    logic signed [VAL_W-1:0] n_tap;
    int                      idx;

    // element update: shift toward the back on insert, toward the front on remove, overwrite on set
    always_comb begin
        idx    = int'(i_ctl.index);
        n_data = r_data;
        unique case (i_ctl.cmd)
            CMD_INS: begin
                if (POS > idx) begin
                    n_data = i_left_data;
                end else if (POS == idx) begin
                    n_data = i_ctl.value;
                end
            end
            CMD_REM: begin
                if (POS >= idx) begin
                    n_data = i_right_data;
                end
            end
            CMD_SET: begin
                if (POS == idx) begin
                    n_data = i_ctl.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // read tap: snapshot of the old element, then moves one cell frontward a cycle
    always_comb begin
        n_tap = i_ctl.load_tap ? r_data : i_right_tap;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

`default_nettype wire

// ===== rtl/circular_array_deque.sv =====
// top level of the indexed deque built as a chain of element cells
`default_nettype none

// Indexed deque of up to CAPACITY signed 32-bit elements with get, set, add and
// remove at a logical index counted from the front. Elements sit in a row of
// cells in logical order; add and remove move every element behind the index
// one cell in the cycle the item is taken, so the store is always up to date.
// An item is taken when i_start is high while o_busy is low. Add and any error
// give their result in the cycle after acceptance and the next item may follow at
// once. Get, set and remove return an element: the old values are copied into
// a tap line that moves one cell toward the front per cycle; o_busy stays high
// while the wanted value walks to the front cell, and the result follows once
// it arrives. Each result is marked by o_strobe high for exactly one cycle;
// there is no way to hold it off, so it must be taken in that cycle.

module circular_array_deque #(
    parameter int CAPACITY = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire dca_pkg::t_item i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output dca_pkg::t_result   o_result
);
    import dca_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    // control registers
    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [IDX_W-1:0]   r_rem;
    logic [IDX_W-1:0]   n_rem;
    logic               r_strobe;
    logic               n_strobe;
    // payload registers
    t_result            r_result;
    t_result            n_result;
    logic [1:0]         r_pend_status;
    logic [1:0]         n_pend_status;
    logic [IDX_W-1:0]   r_pend_count;
    logic [IDX_W-1:0]   n_pend_count;

    // decode of the offered item
    logic               acc;
    t_op                op;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic               full;
    logic               bad;
    t_status            status;
    logic               ok;
    t_cell_ctl          ctl;
    logic [XW-1:0]      next_cnt_x;

    // cell chain wiring
    logic signed [VAL_W-1:0] w_data  [CAPACITY];
    logic signed [VAL_W-1:0] w_tap   [CAPACITY];
    logic signed [VAL_W-1:0] w_left  [CAPACITY];
    logic signed [VAL_W-1:0] w_right [CAPACITY];
    logic signed [VAL_W-1:0] w_rtap  [CAPACITY];

    // item checks
    always_comb begin
        acc   = i_start && (r_state == S_IDLE);
        op    = t_op'(i_item.operation);
        idx_x = XW'(i_item.index);
        cnt_x = XW'(r_count);
        full  = (r_count == CW'(CAPACITY));
        bad   = (op == OP_ADD) ? (idx_x > cnt_x) : (idx_x >= cnt_x);
        if (op == OP_ADD && full) begin
            status = STAT_FULL;
        end else if (bad) begin
            status = STAT_RANGE;
        end else begin
            status = STAT_OK;
        end
        ok = (status == STAT_OK);
    end

    // broadcast to the cells
    always_comb begin
        ctl.load_tap = acc;
        ctl.index    = i_item.index;
        ctl.value    = i_item.value;
        ctl.cmd      = CMD_NONE;
        if (acc && ok) begin
            unique case (op)
                OP_GET: ctl.cmd = CMD_NONE;
                OP_SET: ctl.cmd = CMD_SET;
                OP_ADD: ctl.cmd = CMD_INS;
                OP_REM: ctl.cmd = CMD_REM;
                default: ctl.cmd = CMD_NONE;
            endcase
        end
    end

    // the row of cells
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        if (j == 0) begin : g_first
            assign w_left[j] = '0;
        end else begin : g_inner_l
            assign w_left[j] = w_data[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign w_right[j] = '0;
            assign w_rtap[j]  = '0;
        end else begin : g_inner_r
            assign w_right[j] = w_data[j+1];
            assign w_rtap[j]  = w_tap[j+1];
        end
        dca_cell #(
            .POS (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_left_data  (w_left[j]),
            .i_right_data (w_right[j]),
            .i_right_tap  (w_rtap[j]),
            .o_data       (w_data[j]),
            .o_tap        (w_tap[j])
        );
    end

    // next state, count and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rem         = r_rem;
        n_strobe      = 1'b0;
        n_result      = r_result;
        n_pend_status = r_pend_status;
        n_pend_count  = r_pend_count;
        next_cnt_x    = cnt_x;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (ok && op == OP_ADD) begin
                        n_count = r_count + CW'(1);
                    end else if (ok && op == OP_REM) begin
                        n_count = r_count - CW'(1);
                    end
                    next_cnt_x = XW'(n_count);
                    if (!ok || op == OP_ADD) begin
                        n_strobe            = 1'b1;
                        n_result.read_value = '0;
                        n_result.status     = status;
                        n_result.count      = next_cnt_x[IDX_W-1:0];
                    end else begin
                        n_state       = S_READ;
                        n_rem         = i_item.index;
                        n_pend_status = status;
                        n_pend_count  = next_cnt_x[IDX_W-1:0];
                    end
                end
            end
            S_READ: begin
                if (r_rem == '0) begin
                    n_strobe            = 1'b1;
                    n_result.read_value = w_tap[0];
                    n_result.status     = r_pend_status;
                    n_result.count      = r_pend_count;
                    n_state             = S_IDLE;
                end else begin
                    n_rem = r_rem - IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rem    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rem    <= n_rem;
            r_strobe <= n_strobe;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_result      <= n_result;
        r_pend_status <= n_pend_status;
        r_pend_count  <= n_pend_count;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ok && op == OP_ADD) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted add did not grow the count");

    a_read_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_rem != '0) |=>
            (r_state == S_READ && r_rem == $past(r_rem) - IDX_W'(1)))
        else $error("tap walk lost its place");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_rem == '0) |=> (o_strobe && !o_busy))
        else $error("finished read gave no result");

endmodule

`default_nettype wire

// ===== bench/circular_array_deque_test.sv =====
// testbench of the circular array deque: directed and random items checked against a shadow deque
`default_nettype none

module circular_array_deque_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dca_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int INDEX_TOP  = (1 << IDX_W) - 1;
    localparam int PRINT_CAP  = 100;
    localparam int DRAIN_WAIT = 80;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_item   i_item;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;

    circular_array_deque #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // shadow copy of the deque contents in logical order, front first
    logic signed [VAL_W-1:0] deque_shadow[$];
    // results still owed by the block, oldest first
    t_result                 pending_results[$];

    int error_count;
    int mismatch_prints;
    int results_checked;
    int op_seen[4];
    int full_seen;
    int range_seen;
    int peak_depth;
    bit no_gaps;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("%0t: timeout, %0d results still outstanding", $realtime,
                 pending_results.size());
        $display("simulation failed");
        $finish;
    end

    // apply one operation to the shadow deque and work out the result
    function automatic t_result predict_deque_op(input t_item it);
        t_result res;
        int      depth;
        int      pos;
        depth = deque_shadow.size();
        pos   = int'(it.index);
        res   = '0;
        res.status = STAT_OK;
        op_seen[it.operation]++;
        if (t_op'(it.operation) == OP_ADD) begin
            // full check wins over the index check
            if (depth >= CAPACITY) begin
                res.status = STAT_FULL;
            end else if (pos > depth) begin
                res.status = STAT_RANGE;
            end else begin
                deque_shadow.insert(pos, it.value);
            end
        end else if (pos >= depth) begin
            res.status = STAT_RANGE;
        end else begin
            res.read_value = deque_shadow[pos];
            if (t_op'(it.operation) == OP_SET) begin
                deque_shadow[pos] = it.value;
            end else if (t_op'(it.operation) == OP_REM) begin
                deque_shadow.delete(pos);
            end
        end
        if (res.status == STAT_FULL) full_seen++;
        if (res.status == STAT_RANGE) range_seen++;
        res.count = IDX_W'(deque_shadow.size());
        if (deque_shadow.size() > peak_depth) peak_depth = deque_shadow.size();
        return res;
    endfunction

    // drive one item, hold it until taken, then record what it should return
    task automatic send_item(input t_op op, input int idx, input logic signed [VAL_W-1:0] val);
        t_item it;
        int    gap;
        it.operation = op;
        it.index     = idx[IDX_W-1:0];
        it.value     = val;
        if (!no_gaps && $urandom_range(99) < 9) begin
            gap = $urandom_range(6, 1);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_deque_op(it));
    endtask

    // element values, with the extremes showing up now and then
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // index for an operation: mostly legal, leaning on the ends and the midpoint
    function automatic int pick_index(input t_op op);
        int depth;
        int top;
        depth = deque_shadow.size();
        top   = (op == OP_ADD) ? depth : depth - 1;
        if (top < 0 || $urandom_range(99) < 12) begin
            if ($urandom_range(2) == 0) return top + 1;
            return $urandom_range(INDEX_TOP, top + 1);
        end
        case ($urandom_range(9))
            0:       return 0;
            1:       return top;
            2:       return (depth / 2 <= top) ? depth / 2 : top;
            3:       return (depth / 2 + 1 <= top) ? depth / 2 + 1 : top;
            default: return $urandom_range(top, 0);
        endcase
    endfunction

    // report one mismatch; each result is compared with the oldest expectation below
    task automatic report_mismatch(input string field, input logic [VAL_W-1:0] exp_val,
                                   input logic [VAL_W-1:0] act_val);
        error_count++;
        if (mismatch_prints < PRINT_CAP) begin
            mismatch_prints++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field,
                     exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %0h", $realtime,
                         o_result);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_result.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, o_result.read_value);
                if (o_result.status !== want.status)
                    report_mismatch("status", VAL_W'(want.status),
                                    VAL_W'(o_result.status));
                if (o_result.count !== want.count)
                    report_mismatch("count", VAL_W'(want.count), VAL_W'(o_result.count));
            end
        end
    end

    // error cases on an empty deque, both shift directions, both ends
    task automatic test_directed_cases();
        send_item(OP_GET, 0, 32'h1111_1111);
        send_item(OP_SET, 0, 32'h2222_2222);
        send_item(OP_REM, 0, 32'h3333_3333);
        send_item(OP_ADD, 1, 32'h4444_4444);
        send_item(OP_ADD, 0, 32'h8000_0000);
        send_item(OP_ADD, 1, 32'h7fff_ffff);
        send_item(OP_ADD, 0, 32'h0000_0000);
        send_item(OP_ADD, 1, 32'hffff_ffff);
        send_item(OP_ADD, 3, 32'h1234_5678);
        send_item(OP_ADD, 2, 32'h5a5a_5a5a);
        send_item(OP_GET, 0, 32'h0);
        send_item(OP_GET, 5, 32'h0);
        send_item(OP_GET, 6, 32'h0);
        send_item(OP_SET, 2, 32'ha5a5_a5a5);
        send_item(OP_GET, 2, 32'h0);
        send_item(OP_REM, 3, 32'h0);
        send_item(OP_REM, 3, 32'h0);
        send_item(OP_REM, 0, 32'h0);
        send_item(OP_REM, deque_shadow.size() - 1, 32'h0);
        send_item(OP_GET, INDEX_TOP, 32'h0);
        send_item(OP_ADD, CAPACITY, 32'h0);
        send_item(OP_SET, CAPACITY, 32'hdead_beef);
    endtask

    // fill to capacity, poke the full deque, then empty it again
    task automatic test_fill_and_drain();
        while (deque_shadow.size() < CAPACITY)
            send_item(OP_ADD, $urandom_range(deque_shadow.size(), 0), rand_value());
        send_item(OP_ADD, 0, rand_value());
        send_item(OP_ADD, CAPACITY, rand_value());
        send_item(OP_ADD, INDEX_TOP, rand_value());
        send_item(OP_GET, CAPACITY - 1, 32'h0);
        send_item(OP_GET, CAPACITY, 32'h0);
        send_item(OP_SET, CAPACITY - 1, rand_value());
        while (deque_shadow.size() > 0)
            send_item(OP_REM, $urandom_range(deque_shadow.size() - 1, 0), 32'h0);
        send_item(OP_GET, 0, 32'h0);
    endtask

    // random operations; add_pct steers the deque toward growing or shrinking
    task automatic test_random_mix(input int n, input int add_pct);
        t_op op;
        repeat (n) begin
            if ($urandom_range(99) < add_pct) begin
                op = OP_ADD;
            end else begin
                case ($urandom_range(2))
                    0:       op = OP_GET;
                    1:       op = OP_SET;
                    default: op = OP_REM;
                endcase
            end
            send_item(op, pick_index(op), rand_value());
        end
    endtask

    // random operations issued with no gaps between items
    task automatic test_back_to_back(input int n);
        no_gaps = 1'b1;
        test_random_mix(n, 32);
        no_gaps = 1'b0;
    endtask

    // sequence of tests
    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        no_gaps = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_drain();
        test_random_mix(300, 34);
        test_random_mix(250, 70);
        test_back_to_back(200);
        test_random_mix(250, 15);
        test_random_mix(300, 50);
        test_random_mix(150, 26);

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d get, %0d set, %0d add, %0d remove; %0d full and %0d range errors",
                 op_seen[OP_GET], op_seen[OP_SET], op_seen[OP_ADD], op_seen[OP_REM],
                 full_seen, range_seen);
        $display("peak depth %0d, %0d results checked, %0d mismatches",
                 peak_depth, results_checked, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/dca_pkg.sv
rtl/dca_cell.sv
rtl/circular_array_deque.sv
bench/circular_array_deque_test.sv
